### hw/rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and codes of the priority ready queue scheduler: request and
// response payloads, one table entry, operation and status codes.
// ----------------------------------------------------------------------------
package prqs_pkg;

	localparam logic [1:0] MODE_CREATE   = 2'd0;
	localparam logic [1:0] MODE_STOP     = 2'd1;
	localparam logic [1:0] MODE_DISPATCH = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NONE      = 2'd2;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] thread_id;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted_id;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic        ready;
	} entry_t;

endpackage

### hw/rtl/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Non-preemptive priority scheduler: a ready table in descending priority
// order held in one memory and walked one entry at a time by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: the request is registered, then each entry read takes a read step and an
// evaluate step, and a walk that runs off its end (stop or dispatch without a hit, or
// a create that reaches the head) ends in a read step with no evaluation. Spare mode
// and a full create read none. The finish step then raises the response. One item at
// a time: req_stall holds off the next request until the response is raised.
// Reset clears the entry count, the response valid and the sequencer.
module priority_ready_queue_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  prqs_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output prqs_pkg::rsp_t   rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EV   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	prqs_pkg::entry_t mem [TABLE_DEPTH];
	prqs_pkg::entry_t rd_q;

	logic [1:0]    state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_dec;
	logic [CW-1:0] held_q;
	logic [1:0]    mode_q;
	logic [15:0]   id_q;
	logic [7:0]    prio_q;
	logic [1:0]    status_q;
	logic [15:0]   grant_q;
	logic          rsp_valid_q;
	prqs_pkg::rsp_t rsp_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	prqs_pkg::entry_t wdata;
	prqs_pkg::entry_t new_entry;
	logic             is_create;
	logic             scan_end;
	logic             hit;
	logic             accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_dec   = idx_q - CW'(1);
	assign is_create = (mode_q == prqs_pkg::MODE_CREATE);
	assign scan_end  = (idx_q == held_q);
	assign new_entry = '{id: id_q, prio: prio_q, ready: 1'b1};
	assign hit       = (mode_q == prqs_pkg::MODE_STOP) ? (rd_q.id == id_q) : rd_q.ready;

	// Memory port control. A create walks down from the tail, moving every
	// entry of strictly lower priority one slot up, then drops the new entry
	// into the gap. Stop and dispatch walk up from the head and clear the ready flag of the entry they hit.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = new_entry;
		raddr = '0;
		unique case (state_q)
			ST_RD: begin
				if (is_create) begin
					if (idx_q == '0) begin
						we = 1'b1;
					end else begin
						raddr = idx_dec[AW-1:0];
					end
				end else begin
					raddr = idx_q[AW-1:0];
				end
			end
			ST_EV: begin
				if (is_create) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					if (prio_q > rd_q.prio) begin
						wdata = rd_q;
					end
				end else if (hit) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = '{id: rd_q.id, prio: rd_q.prio, ready: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (state_q == ST_RD) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The finish step raises the next response in the same cycle.
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= req.mode;
						id_q     <= req.thread_id;
						prio_q   <= req.priority_req;
						status_q <= prqs_pkg::STATUS_OK;
						grant_q  <= '0;
						priority if (req.mode == prqs_pkg::MODE_CREATE) begin
							idx_q <= held_q;
							if (held_q == CW'(TABLE_DEPTH)) begin
								status_q <= prqs_pkg::STATUS_FULL;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_RD;
							end
						end else if (req.mode == prqs_pkg::MODE_STOP ||
								req.mode == prqs_pkg::MODE_DISPATCH) begin
							idx_q   <= '0;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: begin
					if (is_create) begin
						if (idx_q == '0) begin
							held_q  <= held_q + CW'(1);
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_EV;
						end
					end else if (scan_end) begin
						status_q <= (mode_q == prqs_pkg::MODE_STOP) ?
							prqs_pkg::STATUS_NOT_FOUND : prqs_pkg::STATUS_NONE;
						state_q  <= ST_FIN;
					end else begin
						state_q <= ST_EV;
					end
				end
				ST_EV: begin
					if (is_create) begin
						if (prio_q > rd_q.prio) begin
							idx_q   <= idx_dec;
							state_q <= ST_RD;
						end else begin
							held_q  <= held_q + CW'(1);
							state_q <= ST_FIN;
						end
					end else if (hit) begin
						if (mode_q == prqs_pkg::MODE_DISPATCH) begin
							grant_q <= rd_q.id;
						end
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					// Wait here only while an older response is still stalled.
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status      <= status_q;
						rsp_q.granted_id  <= grant_q;
						rsp_q.entry_count <= 5'(held_q);
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside the finish step");

	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != $past(held_q)) |-> (held_q == $past(held_q) + CW'(1)))
		else $error("entry count moved by other than one");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_RD || state_q == ST_EV))
		else $error("table written outside a walk");

	a_grant_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && grant_q != '0) |-> (mode_q == prqs_pkg::MODE_DISPATCH))
		else $error("grant on a non-dispatch item");

endmodule
